/* hdl/lss_pkg.sv */
package lss_pkg;

   localparam int VALUE_W     = 32;
   localparam int TYPE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int FILL_W      = 7;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 40;
   localparam int RSP_USER_W  = 3;

   typedef enum logic [TYPE_W-1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_SEARCH = 2'd2
   } req_kind_type;

   localparam logic [STATUS_W-1:0] RSP_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_UNDERFLOW = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_WAIT,
      ST_SEARCH,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic take_pop;
      logic search_step;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] kind;
      logic              empty;
      logic              search_done;
      logic              rsp_free;
   } dp_status_type;

endpackage

/* hdl/lss_ctrl.sv */
module lss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  lss_pkg::dp_status_type status,
   output lss_pkg::ctrl_cmd_type  cmd
);
   import lss_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            unique case (status.kind)
               REQ_POP:    state_in = status.empty ? ST_REPLY : ST_POP_WAIT;
               REQ_SEARCH: state_in = ST_SEARCH;
               default:    state_in = ST_REPLY;
            endcase
         end
         ST_POP_WAIT: begin
            cmd.take_pop = 1'b1;
            state_in     = ST_REPLY;
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (status.search_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* hdl/lss_dp.sv */
module lss_dp #(
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lss_pkg::ctrl_cmd_type                  cmd,
   output lss_pkg::dp_status_type                 status,
   input  logic [lss_pkg::TYPE_W-1:0]             req_type,
   input  logic signed [lss_pkg::VALUE_W-1:0]     req_value,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lss_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [lss_pkg::RSP_USER_W-1:0]         rsp_tuser
);
   import lss_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] ONE  = CW'(1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);
   localparam int PAD_W = RSP_DATA_W - FILL_W - VALUE_W;

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      wr_en, rd_en;
   logic [AW-1:0]             wr_addr, rd_addr;

   logic [CW-1:0]             count_ff, count_in, ptr_ff, ptr_in;
   logic [CW-1:0]             count_dec, ptr_dec;
   logic                      pend_ff, pend_in;
   logic [TYPE_W-1:0]         kind_ff, kind_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic signed [VALUE_W-1:0] popped_ff, popped_in;
   logic                      found_ff, found_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_W-1:0]     rsp_tuser_ff, rsp_tuser_in;
   logic                      full, empty, hit;

   assign full      = (count_ff == FULL);
   assign empty     = (count_ff == '0);
   assign count_dec = count_ff - ONE;
   assign ptr_dec   = ptr_ff - ONE;
   // data read last cycle compared against the key
   assign hit       = pend_ff && (rd_data_ff == key_ff);

   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      popped_in     = popped_ff;
      found_in      = found_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      rd_en         = 1'b0;
      rd_addr       = ptr_dec[AW-1:0];

      if (cmd.capture) begin
         kind_in = req_type;
         key_in  = req_value;
      end

      if (cmd.exec) begin
         status_in = RSP_OK;
         popped_in = '0;
         found_in  = 1'b0;
         unique case (kind_ff)
            REQ_PUSH: begin
               if (full) begin
                  status_in = RSP_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + ONE;
               end
            end
            REQ_POP: begin
               if (empty) begin
                  status_in = RSP_UNDERFLOW;
               end else begin
                  count_in = count_dec;
                  rd_en    = 1'b1;
                  rd_addr  = count_dec[AW-1:0];
               end
            end
            REQ_SEARCH: begin
               ptr_in  = count_ff;
               pend_in = 1'b0;
            end
            default: ;
         endcase
      end

      if (cmd.search_step) begin
         if (hit) begin
            found_in = 1'b1;
         end
         if ((ptr_ff != '0) && !hit) begin
            rd_en   = 1'b1;
            ptr_in  = ptr_dec;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end

      if (cmd.take_pop) begin
         popped_in = rd_data_ff;
      end

      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      if (cmd.load_rsp) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{PAD_W{1'b0}}, FILL_W'(count_ff), popped_ff};
         rsp_tuser_in  = {found_ff, status_ff};
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= key_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ptr_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      popped_ff    <= popped_in;
      found_ff     <= found_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign status.kind        = kind_ff;
   assign status.empty       = empty;
   assign status.search_done = hit || (ptr_ff == '0);
   assign status.rsp_free    = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("fill count beyond depth");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && (kind_ff == REQ_POP) && !empty |=> count_ff == $past(count_dec))
      else $error("pop did not drop the fill count by one");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && (kind_ff == REQ_PUSH) && full |=> $stable(count_ff) && !$past(wr_en))
      else $error("push onto full stack changed state");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp && found_ff |-> (status_ff == RSP_OK) && (popped_ff == '0))
      else $error("found flag with error status or popped word");
`endif

endmodule

/* hdl/lifo_stack_with_search_top.sv */
// Bounded LIFO stack of signed 32-bit words with search. Each request word
// pushes a word, pops the top word or searches the held entries top-down for
// a key (an unused request code changes nothing), and yields exactly one
// response word with status, popped word, found flag and fill level.
// Requests are handled one at a time: a push, or an unused request code,
// goes from the execute step to the reply step; a pop of a non-empty stack
// adds a wait step for the registered read of the entry memory; a search
// walks the held entries top-down after the execute step, stopping early on
// a hit, as the single read port of the entry memory yields one stored word
// per cycle. A finished response sits in an output register; while an
// earlier response there is still unaccepted, the reply step waits. The next
// request is taken in the cycle after the response is loaded. Entries are
// not cleared at reset; only positions below the fill level are ever read.
module lifo_stack_with_search_top #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lss_pkg::REQ_DATA_W-1:0]    req_tdata,  // [31:0] value
   input  logic [lss_pkg::TYPE_W-1:0]        req_tuser,  // [1:0] req_type
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lss_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [31:0] popped_value,
                                                         // [38:32] fill_level, [39] zero
   output logic [lss_pkg::RSP_USER_W-1:0]    rsp_tuser   // [1:0] status, [2] found
);
   import lss_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: accept, execute, wait on memory / walk entries, reply
   lss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // entry memory, fill count, search pointer and response register
   lss_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_type   (req_tuser),
      .req_value  (req_tdata[VALUE_W-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* tb/stack_check_pkg.sv */
package stack_check_pkg;
   import lss_pkg::*;

   localparam int STACK_DEPTH = 64;
   // request code that the block takes but ignores
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  popped;
      logic                found;
      logic [FILL_W-1:0]   fill;
   } stack_reply_type;

   class stack_mirror;
      logic [VALUE_W-1:0] held [STACK_DEPTH];
      int                 held_count;
      stack_reply_type    replies_due [$];
      int unsigned        mismatches;

      function new();
         held_count = 0;
         mismatches = 0;
      endfunction

      // applies one accepted request word to the mirrored stack, queues its reply
      function void take_request(logic [TYPE_W-1:0] kind, logic [VALUE_W-1:0] word);
         stack_reply_type reply;
         int              i;
         reply.status = RSP_OK;
         reply.popped = '0;
         reply.found  = 1'b0;
         case (kind)
            REQ_PUSH: begin
               if (held_count >= STACK_DEPTH) begin
                  reply.status = RSP_OVERFLOW;
               end else begin
                  held[held_count] = word;
                  held_count++;
               end
            end
            REQ_POP: begin
               if (held_count == 0) begin
                  reply.status = RSP_UNDERFLOW;
               end else begin
                  held_count--;
                  reply.popped = held[held_count];
               end
            end
            REQ_SEARCH: begin
               // top down; stops at the first hit
               for (i = held_count - 1; i >= 0 && !reply.found; i--) begin
                  if (held[i] == word) reply.found = 1'b1;
               end
            end
            default: ;
         endcase
         reply.fill = FILL_W'(held_count);
         replies_due.push_back(reply);
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task match_reply(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] popped,
                       logic found, logic [FILL_W-1:0] fill, logic pad);
         stack_reply_type due;
         if (replies_due.size() == 0) begin
            report($sformatf("reply with none due: status %0d popped %h fill %0d",
                             status, popped, fill));
         end else begin
            due = replies_due.pop_front();
            if (status !== due.status)
               report($sformatf("status %0d, wanted %0d", status, due.status));
            if (popped !== due.popped)
               report($sformatf("popped word %h, wanted %h", popped, due.popped));
            if (found !== due.found)
               report($sformatf("found %b, wanted %b", found, due.found));
            if (fill !== due.fill)
               report($sformatf("fill level %0d, wanted %0d", fill, due.fill));
            if (pad !== 1'b0)
               report("spare top bit of reply tdata not zero");
         end
      endtask
   endclass

endpackage

/* tb/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lss_pkg::*;
   import stack_check_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [TYPE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // idle odds per cycle, in percent, for each side
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   // set by the stimulus, taken up by the reply side as a run of stalled cycles
   int          holdoff_req   = 0;
   // request words sent that the block acts on (unused codes not counted)
   int unsigned words_sent    = 0;

   stack_mirror mirror;

   always #5 clock = ~clock;

   lifo_stack_with_search_top #(
      .DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Both channels are watched at the rising edge. A request word updates the
   // mirrored stack the moment it is accepted, so the expected replies queue
   // up in acceptance order; a reply is always for an earlier word.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) mirror.take_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            mirror.match_reply(rsp_tuser[1:0], rsp_tdata[31:0], rsp_tuser[2],
                               rsp_tdata[38:32], rsp_tdata[39]);
      end
   end

   // Reply side: random back-pressure, or a long hold-off when asked for one.
   // The hold-off is counted here, in cycles, independent of the sender.
   initial begin : reply_side
      int holdoff_left;
      holdoff_left = 0;
      forever begin
         @(negedge clock);
         if (holdoff_req != 0) begin
            holdoff_left = holdoff_req;
            holdoff_req  = 0;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog. Slowest sane run: ~1700 words, each a full-depth search, plus
   // random stalls and one long hold-off; this is many times that.
   initial begin : watchdog
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

   // Offers one word from a falling edge and returns at the falling edge after
   // it is taken. Valid stays high straight into the next word unless the
   // sender decides to idle first.
   task automatic drive_item(logic [TYPE_W-1:0] kind, logic [VALUE_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind != REQ_UNUSED) words_sent++;
      @(negedge clock);
   endtask

   // Sender stands back until every reply due has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (mirror.replies_due.size() != 0) @(negedge clock);
   endtask

   // Mostly full-range words; a quarter from a tiny range so that keys repeat
   // and searches hit, plus the signed extremes now and then.
   function automatic logic [VALUE_W-1:0] any_word();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 25) return VALUE_W'($urandom_range(7)) - VALUE_W'(4);
      if (pick < 35) begin
         case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom();
   endfunction

   // A key that is held half the time, when anything is held.
   function automatic logic [VALUE_W-1:0] search_key();
      if (mirror.held_count > 0 && $urandom_range(1) == 1)
         return mirror.held[$urandom_range(mirror.held_count - 1)];
      return any_word();
   endfunction

   // Pushes to full, then overflows, then searches for the deepest entry
   // (longest walk) and for a likely miss.
   task automatic fill_up();
      while (mirror.held_count < STACK_DEPTH) begin
         if ($urandom_range(9) == 0) drive_item(REQ_SEARCH, search_key());
         else drive_item(REQ_PUSH, any_word());
      end
      repeat ($urandom_range(1, 3)) drive_item(REQ_PUSH, any_word());
      drive_item(REQ_SEARCH, mirror.held[0]);
      drive_item(REQ_SEARCH, any_word());
   endtask

   // Pops to empty, then underflows and searches the empty stack.
   task automatic drain_out();
      while (mirror.held_count > 0) begin
         if ($urandom_range(9) == 0) drive_item(REQ_SEARCH, search_key());
         else drive_item(REQ_POP, any_word());
      end
      repeat ($urandom_range(1, 2)) drive_item(REQ_POP, any_word());
      drive_item(REQ_SEARCH, any_word());
   endtask

   task automatic single_op();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 36)      drive_item(REQ_PUSH, any_word());
      else if (pick < 66) drive_item(REQ_POP, any_word());
      else if (pick < 95) drive_item(REQ_SEARCH, search_key());
      else                drive_item(REQ_UNUSED, any_word());
   endtask

   task automatic random_part(int unsigned n);
      int unsigned goal;
      int unsigned pick;
      goal = words_sent + n;
      while (words_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 3)      fill_up();
         else if (pick < 6) drain_out();
         else               single_op();
      end
   endtask

   initial begin : stimulus
      int phase;
      mirror = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-stack corner cases first
      drive_item(REQ_POP, 32'h0000_0000);        // underflow
      drive_item(REQ_SEARCH, 32'h0000_0000);     // search of empty stack
      drive_item(REQ_UNUSED, 32'hFFFF_FFFF);     // ignored code, empty
      // signed extremes in and out
      drive_item(REQ_PUSH, 32'h8000_0000);
      drive_item(REQ_PUSH, 32'h7FFF_FFFF);
      drive_item(REQ_PUSH, 32'h0000_0000);
      drive_item(REQ_PUSH, 32'hFFFF_FFFF);
      drive_item(REQ_SEARCH, 32'h8000_0000);     // hit at the bottom
      drive_item(REQ_SEARCH, 32'hFFFF_FFFF);     // hit at the top
      drive_item(REQ_SEARCH, 32'h5555_AAAA);     // miss, full walk
      drive_item(REQ_UNUSED, 32'hA5A5_5A5A);     // ignored code, non-empty
      repeat (4) drive_item(REQ_POP, 32'hFFFF_FFFF);
      drive_item(REQ_POP, 32'h0000_0000);        // underflow again
      wait_drained();

      // random, under three idling regimes
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 46;
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 2) begin
            // long reply stall while words keep coming: the block backs up
            // and must stall its input
            wait_drained();
            holdoff_req = 400;
            repeat (30) begin
               if ($urandom_range(3) == 0) drive_item(REQ_SEARCH, search_key());
               else drive_item(REQ_PUSH, any_word());
            end
         end
         random_part(535);
         if (phase == 0) wait_drained();
      end

      wait_drained();
      // settle: a search of a full stack is the slowest thing in flight
      repeat (100) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/lss_pkg.sv
hdl/lss_ctrl.sv
hdl/lss_dp.sv
hdl/lifo_stack_with_search_top.sv
tb/stack_check_pkg.sv
tb/tb.sv
